/* hdl/gmd_pkg.sv */
// shared constants, types and the arctangent table for the gradient magnitude and direction block
package gmd_pkg;

  localparam int GRAD_WIDTH    = 11;
  localparam int CORDIC_STAGES = 14;
  localparam int MAG_W         = 14;
  localparam int ANG_W         = 13;

  localparam int PRESCALE   = 40 - GRAD_WIDTH;
  localparam int XY_W       = 43;
  localparam int ACC_W      = 34;
  localparam int ANG_FRAC   = 20;
  localparam int ANG_LIMIT  = 2048;

  localparam int SQ_W       = 2 * GRAD_WIDTH + 6;
  localparam int ROOT_W     = GRAD_WIDTH + 3;
  localparam int REM_W      = ROOT_W + 2;
  localparam int REM_T_W    = REM_W + 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int MAG_EXT_W  = (ROOT_W > MAG_W) ? ROOT_W + 1 : MAG_W + 1;

  localparam int N_STAGES   = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
  localparam int IDX_W      = $clog2(N_STAGES);

  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = 5;

  localparam logic signed [ACC_W-1:0] ACC_PI   = ACC_W'(64'd1 << 31);
  localparam logic signed [ACC_W:0]   ANG_HALF = (ACC_W + 1)'(64'd1 << (ANG_FRAC - 1));

  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
    logic [SQ_W-1:0]         rad;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
  } gmd_data_t;

  function automatic logic signed [ACC_W-1:0] gmd_atan(input logic [ATAN_IDX_W-1:0] i);
    logic signed [ACC_W-1:0] r;
    r = '0;
    if (int'(i) < ATAN_ENTRIES) begin
      r = ACC_W'({1'b0, ATAN_TURNS[i]});
    end
    return r;
  endfunction

endpackage

/* hdl/gmd_front.sv */
// input stage: squares for the magnitude and quadrant folding for the angle
module gmd_front import gmd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [GRAD_WIDTH-1:0] grad_x_i,
  input  logic signed [GRAD_WIDTH-1:0] grad_y_i,
  output logic                         valid_o,
  output gmd_data_t                    data_o
);

  logic [GRAD_WIDTH-1:0]   abs_x, abs_y;
  logic [2*GRAD_WIDTH-1:0] sq_x, sq_y;
  logic [2*GRAD_WIDTH:0]   sq_sum;
  logic signed [XY_W-1:0]  x_s, y_s;
  logic                    valid_q;
  gmd_data_t               data_d, data_q;

  always_comb begin
    abs_x  = grad_x_i[GRAD_WIDTH-1] ? GRAD_WIDTH'(-grad_x_i) : grad_x_i;
    abs_y  = grad_y_i[GRAD_WIDTH-1] ? GRAD_WIDTH'(-grad_y_i) : grad_y_i;
    sq_x   = abs_x * abs_x;
    sq_y   = abs_y * abs_y;
    sq_sum = (2 * GRAD_WIDTH + 1)'(sq_x) + (2 * GRAD_WIDTH + 1)'(sq_y);
    x_s    = XY_W'(grad_x_i) <<< PRESCALE;
    y_s    = XY_W'(grad_y_i) <<< PRESCALE;

    data_d      = '0;
    data_d.rad  = SQ_W'({sq_sum, 6'b0});
    data_d.zero = (grad_x_i == '0) && (grad_y_i == '0);
    if (grad_x_i[GRAD_WIDTH-1]) begin
      data_d.x   = -x_s;
      data_d.y   = -y_s;
      data_d.acc = grad_y_i[GRAD_WIDTH-1] ? -ACC_PI : ACC_PI;
    end else begin
      data_d.x   = x_s;
      data_d.y   = y_s;
      data_d.acc = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/gmd_stage.sv */
// one pipeline stage: a cordic vectoring iteration and one square root digit
module gmd_stage import gmd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic             valid_i,
  input  gmd_data_t        data_i,
  output logic             valid_o,
  output gmd_data_t        data_o
);

  logic signed [XY_W-1:0]  xs, ys;
  logic signed [ACC_W-1:0] atan_v;
  logic [REM_T_W-1:0]      rem_t, trial;
  logic                    valid_q;
  gmd_data_t               data_d, data_q;

  always_comb begin
    data_d = data_i;
    xs     = data_i.x >>> idx_i;
    ys     = data_i.y >>> idx_i;
    atan_v = gmd_atan(ATAN_IDX_W'(idx_i));
    rem_t  = {data_i.rem, data_i.rad[SQ_W-1 -: 2]};
    trial  = REM_T_W'({data_i.root, 2'b01});

    if (int'(idx_i) < CORDIC_STAGES) begin
      if (!data_i.y[XY_W-1]) begin
        data_d.x   = data_i.x + ys;
        data_d.y   = data_i.y - xs;
        data_d.acc = data_i.acc + atan_v;
      end else begin
        data_d.x   = data_i.x - ys;
        data_d.y   = data_i.y + xs;
        data_d.acc = data_i.acc - atan_v;
      end
    end

    if (int'(idx_i) < SQRT_STEPS) begin
      data_d.rad = {data_i.rad[SQ_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        data_d.rem  = REM_W'(rem_t - trial);
        data_d.root = {data_i.root[ROOT_W-2:0], 1'b1};
      end else begin
        data_d.rem  = REM_W'(rem_t);
        data_d.root = {data_i.root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/gmd_final.sv */
// output stage: magnitude rounding, angle rounding and saturation, output register
module gmd_final import gmd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  gmd_data_t               data_i,
  output logic                    valid_o,
  output logic [MAG_W-1:0]        magnitude_o,
  output logic signed [ANG_W-1:0] angle_o
);

  logic [MAG_EXT_W-1:0]    mag_ext;
  logic                    round_up;
  logic signed [ACC_W:0]   acc_r, ang_r;
  logic signed [ANG_W-1:0] ang_sat;
  logic                    valid_q;
  logic [MAG_W-1:0]        mag_d, mag_q;
  logic signed [ANG_W-1:0] ang_d, ang_q;

  always_comb begin
    round_up = (REM_T_W'(data_i.rem) > REM_T_W'(data_i.root));
    mag_ext  = MAG_EXT_W'(data_i.root) + MAG_EXT_W'(round_up);
    mag_d    = mag_ext[MAG_W-1:0];

    acc_r = (ACC_W + 1)'(data_i.acc) + ANG_HALF;
    ang_r = acc_r >>> ANG_FRAC;
    if (ang_r > (ACC_W + 1)'(ANG_LIMIT)) begin
      ang_sat = ANG_W'(ANG_LIMIT);
    end else if (ang_r < -((ACC_W + 1)'(ANG_LIMIT))) begin
      ang_sat = -(ANG_W'(ANG_LIMIT));
    end else begin
      ang_sat = ANG_W'(ang_r);
    end
    ang_d = data_i.zero ? '0 : ang_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      ang_q <= ang_d;
    end
  end

  assign valid_o     = valid_q;
  assign magnitude_o = mag_q;
  assign angle_o     = ang_q;

endmodule

/* hdl/gradient_magnitude_direction.sv */
// top level of the gradient magnitude and direction pipeline
//
//   channel   handshake            payload
//   input     valid_i / stall_o    grad_x_i, grad_y_i
//   output    valid_o / stall_i    magnitude_o, angle_o
//
// one transaction per cycle sustained while stall_i stays low; the registers in order are
// the input stage, one stage per cordic iteration / root digit, and the output register
// the longest path is one 43-bit cordic add/sub or one root-digit subtract per stage
// reset clears only the valid bits; no clearing pass
// each stage holds when it is full and the stage after it holds, so bubbles
// close up and new transactions are taken while a result waits on the output
module gradient_magnitude_direction import gmd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [GRAD_WIDTH-1:0] grad_x_i,
  input  logic signed [GRAD_WIDTH-1:0] grad_y_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [MAG_W-1:0]             magnitude_o,
  output logic signed [ANG_W-1:0]      angle_o
);

  logic [N_STAGES+1:0] en;
  logic [N_STAGES+1:0] vld;
  gmd_data_t           data_s [N_STAGES+1];

  assign en[N_STAGES+1] = !vld[N_STAGES+1] || !stall_i;

  for (genvar k = 0; k <= N_STAGES; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign stall_o = !en[0];

  gmd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en[0]),
    .valid_i  (valid_i),
    .grad_x_i (grad_x_i),
    .grad_y_i (grad_y_i),
    .valid_o  (vld[0]),
    .data_o   (data_s[0])
  );

  for (genvar k = 1; k <= N_STAGES; k++) begin : g_stage
    gmd_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[k]),
      .idx_i   (IDX_W'(k - 1)),
      .valid_i (vld[k-1]),
      .data_i  (data_s[k-1]),
      .valid_o (vld[k]),
      .data_o  (data_s[k])
    );
  end

  gmd_final u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en[N_STAGES+1]),
    .valid_i     (vld[N_STAGES]),
    .data_i      (data_s[N_STAGES]),
    .valid_o     (vld[N_STAGES+1]),
    .magnitude_o (magnitude_o),
    .angle_o     (angle_o)
  );

  assign valid_o = vld[N_STAGES+1];

endmodule

/* hdl/gmd_checker.sv */
// port-level assertions for the gradient magnitude and direction block
module gmd_checker import gmd_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         valid_i,
  input logic                         stall_o,
  input logic signed [GRAD_WIDTH-1:0] grad_x_i,
  input logic signed [GRAD_WIDTH-1:0] grad_y_i,
  input logic                         valid_o,
  input logic                         stall_i,
  input logic [MAG_W-1:0]             magnitude_o,
  input logic signed [ANG_W-1:0]      angle_o
);

  // stalled input transaction stays
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stall_o |=> valid_i && $stable(grad_x_i) && $stable(grad_y_i))
    else $error("input transaction changed while stalled");

  // stalled result transaction stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(magnitude_o) && $stable(angle_o))
    else $error("output transaction changed while stalled");

  // empty pipeline end never pushes back on the input
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("input stalled while output register empty");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (angle_o <= ANG_W'(ANG_LIMIT)) && (angle_o >= -(ANG_W'(ANG_LIMIT))))
    else $error("angle out of range");

  // only the zero vector rounds to zero magnitude, and it has angle zero
  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (magnitude_o == '0) |-> (angle_o == '0))
    else $error("zero magnitude with nonzero angle");

endmodule

bind gradient_magnitude_direction gmd_checker u_gmd_checker (.*);

/* verif/gradient_magnitude_direction_test.sv */
// self-checking testbench for the gradient magnitude and direction pipeline
module gradient_magnitude_direction_test import gmd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [GRAD_WIDTH-1:0] gx;
    logic signed [GRAD_WIDTH-1:0] gy;
    bit                           drain;
  } grad_pair_t;

  typedef struct {
    logic [MAG_W-1:0]        mag;
    logic signed [ANG_W-1:0] ang;
  } gradient_t;

  localparam int RANDOM_PAIRS = 500;
  localparam int TAIL_CYCLES  = N_STAGES + 8;

  logic                         clk_i;
  logic                         rst_ni   = 1'b0;
  logic                         valid_i  = 1'b0;
  logic                         stall_o;
  logic signed [GRAD_WIDTH-1:0] grad_x_i = '0;
  logic signed [GRAD_WIDTH-1:0] grad_y_i = '0;
  logic                         valid_o;
  logic                         stall_i  = 1'b0;
  logic [MAG_W-1:0]             magnitude_o;
  logic signed [ANG_W-1:0]      angle_o;

  grad_pair_t grad_queue[$];
  gradient_t  expected_gradients[$];

  bit in_taken   = 1'b0;
  bit out_taken  = 1'b0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  int send_wait  = 0;
  int recv_wait  = 0;
  int errors     = 0;

  gradient_magnitude_direction DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .grad_x_i    (grad_x_i),
    .grad_y_i    (grad_y_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .magnitude_o (magnitude_o),
    .angle_o     (angle_o)
  );

  function automatic gradient_t predict_gradient(logic signed [GRAD_WIDTH-1:0] gx,
                                                 logic signed [GRAD_WIDTH-1:0] gy);
    gradient_t       res;
    longint          x, y, xs, ys, acc, r;
    longint unsigned sq, rem, root, bitv;
    x    = longint'(gx);
    y    = longint'(gy);
    sq   = longint'(x * x + y * y) * 64;
    rem  = sq;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (sq - root * root > root) root = root + 1;
    res.mag = root[MAG_W-1:0];

    r = 0;
    if (gx != 0 || gy != 0) begin
      x   = longint'(gx) <<< PRESCALE;
      y   = longint'(gy) <<< PRESCALE;
      acc = 0;
      if (x < 0) begin
        acc = (gy >= 0) ? (longint'(1) <<< 31) : -(longint'(1) <<< 31);
        x   = -x;
        y   = -y;
      end
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x   = x + ys;
          y   = y - xs;
          acc = acc + longint'(ATAN_TURNS[i]);
        end else begin
          x   = x - ys;
          y   = y + xs;
          acc = acc - longint'(ATAN_TURNS[i]);
        end
      end
      r = (acc + (longint'(1) <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
      if (r > ANG_LIMIT) r = ANG_LIMIT;
      if (r < -ANG_LIMIT) r = -ANG_LIMIT;
    end
    res.ang = r[ANG_W-1:0];
    return res;
  endfunction

  function automatic int draw_wait(bit burst);
    if (burst) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : $urandom_range(0, 1);
  endfunction

  function automatic logic signed [GRAD_WIDTH-1:0] near_value(int center, int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 1023) v = 1023;
    if (v < -1024) v = -1024;
    return v[GRAD_WIDTH-1:0];
  endfunction

  task automatic add_pair(int gx, int gy, bit drain = 1'b0);
    grad_pair_t p;
    p.gx    = gx[GRAD_WIDTH-1:0];
    p.gy    = gy[GRAD_WIDTH-1:0];
    p.drain = drain;
    grad_queue.push_back(p);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor: outputs first, then the input transaction of the same edge
  always @(posedge clk_i) begin
    gradient_t want;
    in_taken  = rst_ni && valid_i && !stall_o;
    out_taken = rst_ni && valid_o && !stall_i;
    if (out_taken) begin
      if (expected_gradients.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: magnitude %0d angle %0d", magnitude_o, angle_o);
        errors++;
      end else begin
        want = expected_gradients.pop_front();
        if (magnitude_o !== want.mag || angle_o !== want.ang) begin
          if (errors < 10)
            $display("mismatch: magnitude exp %0d got %0d, angle exp %0d got %0d",
                     want.mag, magnitude_o, want.ang, angle_o);
          errors++;
        end
      end
    end
    if (in_taken) expected_gradients.push_back(predict_gradient(grad_x_i, grad_y_i));
  end

  // driver
  always @(negedge clk_i) begin
    grad_pair_t item;
    logic       next_valid;
    if (rst_ni) begin
      next_valid = valid_i && !in_taken;
      if (!next_valid) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (grad_queue.size() != 0 &&
                     !(grad_queue[0].drain && expected_gradients.size() != 0)) begin
          item       = grad_queue.pop_front();
          grad_x_i  <= item.gx;
          grad_y_i  <= item.gy;
          next_valid = 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_wait = draw_wait(send_burst);
        end
      end
      valid_i <= next_valid;
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_wait = draw_wait(recv_burst);
      end
      if (recv_wait != 0) begin
        recv_wait--;
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int                           sel;
    logic signed [GRAD_WIDTH-1:0] gx, gy;
    grad_pair_t                   p;
    int                           extremes[6] = '{-1024, -1023, -1, 0, 1, 1023};

    // zero vector, axes, corners, negative x axis and its neighbors
    add_pair(0, 0);
    add_pair(1023, 0);
    add_pair(-1024, 0);
    add_pair(0, 1023);
    add_pair(0, -1024);
    add_pair(1023, 1023);
    add_pair(-1024, -1024);
    add_pair(-1024, 1023);
    add_pair(1023, -1024);
    add_pair(-1, 0);
    add_pair(-5, 0);
    add_pair(-1024, 1);
    add_pair(-1024, -1);
    add_pair(-1, -1);
    add_pair(-1, 1);
    add_pair(1, -1);
    add_pair(1, 0);
    add_pair(0, 1);
    add_pair(0, -1);
    add_pair(3, 4);
    add_pair(-1023, -1);
    add_pair(-1, -1024);
    add_pair(-1000, 0);

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      sel = $urandom_range(0, 6);
      case (sel)
        0, 1: begin
          gx = GRAD_WIDTH'($urandom);
          gy = GRAD_WIDTH'($urandom);
        end
        2: begin
          gx = near_value(0, 8);
          gy = near_value(0, 8);
        end
        3: begin
          gx = GRAD_WIDTH'($urandom);
          gy = '0;
          if ($urandom_range(0, 1) == 1) begin
            gy = gx;
            gx = '0;
          end
        end
        4: begin
          gx = GRAD_WIDTH'(extremes[$urandom_range(0, 5)]);
          gy = GRAD_WIDTH'(extremes[$urandom_range(0, 5)]);
        end
        5: begin
          gx = near_value(-600, 420);
          gy = near_value(0, 2);
        end
        default: begin
          gx = GRAD_WIDTH'($urandom);
          gy = ($urandom_range(0, 1) == 1) ? gx : -gx;
          gy = near_value(int'(gy), 1);
        end
      endcase
      p.gx    = gx;
      p.gy    = gy;
      p.drain = (n == 0) || (n == RANDOM_PAIRS / 2);
      grad_queue.push_back(p);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (grad_queue.size() != 0 || valid_i || expected_gradients.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0 && expected_gradients.size() == 0) begin
      $display("[gradient_magnitude_direction] OK");
    end else begin
      $display("[gradient_magnitude_direction] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[gradient_magnitude_direction] ERROR");
    $finish;
  end

endmodule
